// ===== rtl/brf_pkg.sv =====
// Package for the byte ring FIFO with peek: sizes, function codes and the
// packed input and result item types. No dependencies.
`timescale 1ns / 1ps

package brf_pkg;

  // Ring storage depth in bytes and the derived index widths.
  localparam int DEPTH   = 4096;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LEN_W   = ADDR_W + 1;

  // Longest run of bytes that one enqueue or read may ask for.
  localparam int MAX_RUN = 64;

  // Fixed field widths of the item formats.
  localparam int RUN_W   = 7;
  localparam int CFG_W   = 13;
  localparam int CNT_W   = 12;

  typedef enum logic [1:0] {
    FN_ENQ  = 2'd0,
    FN_DEQ  = 2'd1,
    FN_PEEK = 2'd2,
    FN_PKT  = 2'd3
  } func_t;

  typedef enum logic {
    ST_DONE     = 1'b0,
    ST_REJECTED = 1'b1
  } status_t;

  typedef struct packed {
    func_t            func;
    logic [7:0]       data_in;
    logic             first;
    logic [RUN_W-1:0] run_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       data_out;
    logic             last;
    status_t          status;
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] free_count;
  } out_item_t;

endpackage

// ===== rtl/brf_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; used for the ring storage.
`timescale 1ns / 1ps

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/byte_ring_fifo_with_peek_core.sv =====
// Top level of the byte ring FIFO with peek: pointer bookkeeping, the read
// sequencer and the result register. Depends on brf_pkg and brf_ram.
`timescale 1ns / 1ps

// The block stores bytes in a ring of ring_length slots (clamped to 2 up to
// the storage depth) and holds at most ring_length - 1 of them. An enqueue
// run is sent one byte per transfer; space for the whole run is checked on
// the byte marked first, and the run is then stored or dropped as a whole.
// Every enqueue transfer gives exactly one result, and further input is taken
// while the result register is free. A dequeue, peek or packet dequeue asks
// for run_length bytes and either gets one rejected result or one result per
// byte. An accepted read holds the input off until its last byte is loaded:
// the request is taken, then each byte is read from memory and loaded into
// the result register. The ring is a single memory with one read port, so
// one byte is fetched per cycle while the result channel is not stalled, and
// back-pressure on it stretches the hold-off further. A rejected read gives
// its result without leaving the idle state. Every result carries the used
// and free counts as they stand after the item. A write of the ring_length
// register empties the ring and drops any enqueue run in progress; it should
// only be issued while the block is idle, and it takes precedence over an
// input transfer offered in the same cycle. The storage is not cleared after
// reset, so a byte read from a slot never written holds an arbitrary value.
module byte_ring_fifo_with_peek_core
  import brf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,

  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,

  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t            state_r, state_nxt;

  // Ring length and pointers. All pointers always lie below len_r.
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [ADDR_W-1:0] pkt_idx_r, pkt_idx_nxt;
  logic              run_acc_r, run_acc_nxt;
  logic [RUN_W-1:0]  run_left_r, run_left_nxt;

  // Read sequencer.
  func_t             func_r, func_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [RUN_W-1:0]  rem_r, rem_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic [LEN_W-1:0]  used_hold_r, used_hold_nxt;
  logic [LEN_W-1:0]  free_hold_r, free_hold_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  // Memory ports.
  logic              ram_we;
  logic [7:0]        ram_rdata;
  logic              ram_re;

  logic              in_fire;
  logic              cfg_fire;
  logic              slot_free;
  logic              load;
  logic              issue;

  logic [LEN_W-1:0]  used_l;
  logic [LEN_W-1:0]  free_l;
  logic [LEN_W-1:0]  n_l;
  logic              lenok;
  logic              acc0;
  logic [RUN_W-1:0]  left0;

  function automatic logic [ADDR_W-1:0] wrap_next(input logic [ADDR_W-1:0] a,
                                                  input logic [LEN_W-1:0]  len);
    logic [LEN_W-1:0] s;
    s = {1'b0, a} + LEN_W'(1);
    return (s >= len) ? '0 : s[ADDR_W-1:0];
  endfunction

  // A register write wins over an input transfer offered in the same cycle.
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;

  assign load  = (state_r == S_RUN) && pend_r && slot_free;
  assign issue = (state_r == S_RUN) && (rem_r != '0) && (!pend_r || load);

  // Occupancy as measured from the read pointer.
  assign used_l = (wr_idx_r >= rd_idx_r) ? ({1'b0, wr_idx_r} - {1'b0, rd_idx_r})
                                         : ({1'b0, wr_idx_r} + len_r - {1'b0, rd_idx_r});
  assign free_l = len_r - LEN_W'(1) - used_l;
  assign n_l    = LEN_W'(in_item.run_length);
  assign lenok  = (in_item.run_length != '0) && (in_item.run_length <= RUN_W'(MAX_RUN));

  // Run state as seen by this enqueue byte: a first byte restarts the run.
  always_comb begin
    if (in_item.first) begin
      acc0  = lenok && (free_l >= n_l);
      left0 = acc0 ? in_item.run_length : '0;
    end else begin
      acc0  = run_acc_r;
      left0 = run_left_r;
    end
  end

  assign ram_we = in_fire && (in_item.func == FN_ENQ)
                  && acc0 && (left0 != '0) && (free_l != '0);
  assign ram_re = issue;

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    pkt_idx_nxt   = pkt_idx_r;
    run_acc_nxt   = run_acc_r;
    run_left_nxt  = run_left_r;
    func_nxt      = func_r;
    addr_nxt      = addr_r;
    rem_nxt       = rem_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    used_hold_nxt = used_hold_r;
    free_hold_nxt = free_hold_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    if (cfg_fire) begin
      if (int'(cfg_data) < 2) begin
        len_nxt = LEN_W'(2);
      end else if (int'(cfg_data) > DEPTH) begin
        len_nxt = LEN_W'(DEPTH);
      end else begin
        len_nxt = LEN_W'(cfg_data);
      end
      rd_idx_nxt   = '0;
      wr_idx_nxt   = '0;
      pkt_idx_nxt  = '0;
      run_acc_nxt  = 1'b0;
      run_left_nxt = '0;
    end else if (in_fire) begin
      out_valid_nxt       = 1'b1;
      out_nxt.data_out    = '0;
      out_nxt.last        = 1'b1;
      if (in_item.func == FN_ENQ) begin
        if (ram_we) begin
          wr_idx_nxt   = wrap_next(wr_idx_r, len_r);
          run_left_nxt = left0 - RUN_W'(1);
          run_acc_nxt  = (left0 != RUN_W'(1));
          out_nxt.status     = ST_DONE;
          out_nxt.used_count = CNT_W'(used_l + LEN_W'(1));
          out_nxt.free_count = CNT_W'(free_l - LEN_W'(1));
        end else begin
          if (!in_item.first) begin
            run_acc_nxt  = 1'b0;
            run_left_nxt = '0;
          end else begin
            run_acc_nxt  = acc0;
            run_left_nxt = left0;
          end
          out_nxt.status     = ST_REJECTED;
          out_nxt.used_count = CNT_W'(used_l);
          out_nxt.free_count = CNT_W'(free_l);
        end
      end else if (!lenok || (used_l < n_l)) begin
        out_nxt.status     = ST_REJECTED;
        out_nxt.used_count = CNT_W'(used_l);
        out_nxt.free_count = CNT_W'(free_l);
      end else begin
        // Accepted read: the bytes come out of the sequencer instead.
        out_valid_nxt = out_valid_r && !out_ready;
        out_nxt       = out_r;
        state_nxt     = S_RUN;
        func_nxt      = in_item.func;
        addr_nxt      = (in_item.func == FN_PKT) ? pkt_idx_r : rd_idx_r;
        rem_nxt       = in_item.run_length;
        if (in_item.func == FN_DEQ) begin
          used_hold_nxt = used_l - n_l;
          free_hold_nxt = free_l + n_l;
        end else begin
          used_hold_nxt = used_l;
          free_hold_nxt = free_l;
        end
      end
    end

    if (issue) begin
      addr_nxt      = wrap_next(addr_r, len_r);
      rem_nxt       = rem_r - RUN_W'(1);
      pend_last_nxt = (rem_r == RUN_W'(1));
      if (func_r == FN_DEQ) begin
        rd_idx_nxt = wrap_next(addr_r, len_r);
      end else if (func_r == FN_PKT) begin
        pkt_idx_nxt = wrap_next(addr_r, len_r);
      end
    end

    if (load) begin
      out_valid_nxt      = 1'b1;
      out_nxt.data_out   = ram_rdata;
      out_nxt.last       = pend_last_r;
      out_nxt.status     = ST_DONE;
      out_nxt.used_count = CNT_W'(used_hold_r);
      out_nxt.free_count = CNT_W'(free_hold_r);
      if (pend_last_r) begin
        state_nxt = S_IDLE;
      end
    end

    if (issue) begin
      pend_nxt = 1'b1;
    end else if (load) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LEN_W'(DEPTH);
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      pkt_idx_r   <= '0;
      run_acc_r   <= 1'b0;
      run_left_r  <= '0;
      rem_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      pkt_idx_r   <= pkt_idx_nxt;
      run_acc_r   <= run_acc_nxt;
      run_left_r  <= run_left_nxt;
      rem_r       <= rem_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r      <= func_nxt;
    addr_r      <= addr_nxt;
    pend_last_r <= pend_last_nxt;
    used_hold_r <= used_hold_nxt;
    free_hold_r <= free_hold_nxt;
    out_r       <= out_nxt;
  end

  brf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (in_item.data_in),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== bench/brf_ring_check.sv =====
// Transfer monitor for the byte ring FIFO with peek: predicts the results of
// every accepted input transfer and compares them with the result channel.
// Depends on brf_pkg.
`timescale 1ns / 1ps

module brf_ring_check
  import brf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_item,

  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_item,

  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,

  output int unsigned      mismatch_count,
  output int unsigned      results_pending,
  output int unsigned      pkt_written_span
);

  logic [7:0]        ring_mirror [DEPTH];
  bit                slot_written [DEPTH];
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] pkt_ptr;
  logic [CFG_W-1:0]  ring_len_reg;
  bit                run_open;
  int unsigned       run_remaining;
  out_item_t         results_due [$];
  int unsigned       fail_tally;
  int unsigned       results_seen;

  function automatic int unsigned slots_in_ring();
    int unsigned l;
    l = ring_len_reg;
    if (l < 2) l = 2;
    if (l > DEPTH) l = DEPTH;
    return l;
  endfunction

  function automatic int unsigned next_slot(input int unsigned p, input int unsigned len);
    return (p + 1 >= len) ? 0 : p + 1;
  endfunction

  function automatic int unsigned bytes_held(input int unsigned len);
    int unsigned w;
    int unsigned r;
    w = wr_ptr % len;
    r = rd_ptr % len;
    return (w >= r) ? w - r : w + len - r;
  endfunction

  // Number of consecutive written slots from the packet pointer, capped at a
  // full run. A packet read no longer than this never touches a stale slot.
  function automatic int unsigned written_run_at_pkt();
    int unsigned len;
    int unsigned p;
    int unsigned k;
    len = slots_in_ring();
    p = pkt_ptr % len;
    for (k = 0; k < MAX_RUN; k++) begin
      if (!slot_written[p]) return k;
      p = next_slot(p, len);
    end
    return MAX_RUN;
  endfunction

  function automatic void queue_result(input logic [7:0] data, input logic fin,
                                       input status_t st, input int unsigned used,
                                       input int unsigned free_slots);
    out_item_t r;
    r.data_out   = data;
    r.last       = fin;
    r.status     = st;
    r.used_count = CNT_W'(used);
    r.free_count = CNT_W'(free_slots);
    results_due.push_back(r);
  endfunction

  function automatic void empty_ring();
    rd_ptr        = '0;
    wr_ptr        = '0;
    pkt_ptr       = '0;
    run_open      = 1'b0;
    run_remaining = 0;
  endfunction

  // Works out the results of one accepted input transfer and updates the
  // mirrored ring state.
  task automatic play_ring_op(input in_item_t it);
    int unsigned len;
    int unsigned used;
    int unsigned n;
    int unsigned p;
    int unsigned after_used;
    int unsigned k;
    bit          len_ok;
    bit          stored;
    len    = slots_in_ring();
    used   = bytes_held(len);
    n      = it.run_length;
    len_ok = (n >= 1) && (n <= MAX_RUN);
    if (it.func == FN_ENQ) begin
      stored = 1'b0;
      if (it.first) begin
        run_open      = 1'b0;
        run_remaining = 0;
        if (len_ok && (len - 1 - used) >= n) begin
          run_open      = 1'b1;
          run_remaining = n;
        end
      end
      if (run_open && run_remaining > 0 && (len - 1 - used) > 0) stored = 1'b1;
      if (stored) begin
        p = wr_ptr % len;
        ring_mirror[p]  = it.data_in;
        slot_written[p] = 1'b1;
        wr_ptr = ADDR_W'(next_slot(p, len));
        run_remaining--;
        if (run_remaining == 0) run_open = 1'b0;
      end else if (!it.first) begin
        run_open      = 1'b0;
        run_remaining = 0;
      end
      used = bytes_held(len);
      queue_result(8'h00, 1'b1, stored ? ST_DONE : ST_REJECTED, used, len - 1 - used);
    end else if (!len_ok || used < n) begin
      queue_result(8'h00, 1'b1, ST_REJECTED, used, len - 1 - used);
    end else begin
      p = ((it.func == FN_PKT) ? pkt_ptr : rd_ptr) % len;
      after_used = (it.func == FN_DEQ) ? used - n : used;
      for (k = 0; k < n; k++) begin
        queue_result(ring_mirror[p], k + 1 == n, ST_DONE, after_used,
                     len - 1 - after_used);
        p = next_slot(p, len);
      end
      if (it.func == FN_DEQ) rd_ptr = ADDR_W'(p);
      else if (it.func == FN_PKT) pkt_ptr = ADDR_W'(p);
    end
  endtask

  task automatic report_mismatch(input string what);
    fail_tally++;
    if (fail_tally <= 40) $display("ring check: result %0d at %0t: %s",
                                   results_seen, $time, what);
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result, data_out %0d", got.data_out));
      return;
    end
    want = results_due.pop_front();
    if (got.data_out !== want.data_out)
      report_mismatch($sformatf("data_out %0d, expected %0d", got.data_out, want.data_out));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.used_count !== want.used_count)
      report_mismatch($sformatf("used_count %0d, expected %0d",
                                got.used_count, want.used_count));
    if (got.free_count !== want.free_count)
      report_mismatch($sformatf("free_count %0d, expected %0d",
                                got.free_count, want.free_count));
  endtask

  // Outputs are published with nonblocking updates, so the stimulus side
  // always sees the state as of the previous clock edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      ring_len_reg = 13'd4096;
      empty_ring();
      results_due.delete();
      foreach (slot_written[i]) slot_written[i] = 1'b0;
      fail_tally   = 0;
      results_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        compare_result(out_item);
        results_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        ring_len_reg = cfg_data;
        empty_ring();
      end
      if (in_valid && in_ready) play_ring_op(in_item);
    end
    mismatch_count   <= fail_tally;
    results_pending  <= results_due.size();
    pkt_written_span <= written_run_at_pkt();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the byte ring FIFO with peek bench: clock, reset, stimulus, random
// idling on both channels and the final verdict. Depends on brf_pkg,
// brf_ring_check and byte_ring_fifo_with_peek_core.
`timescale 1ns / 1ps

module testbench;
  import brf_pkg::*;

  // Generous ceiling on the whole run, far above the slowest legal run with
  // every read at full length and every transfer waiting out a long gap.
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  // Cycles to let pass once the last expected result has arrived.
  localparam int unsigned QUIET_CYCLES = 8;
  // Length of the deliberate hold-off on the result channel.
  localparam int unsigned LONG_STALL   = 150;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_item;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  int unsigned      mismatch_count;
  int unsigned      results_pending;
  int unsigned      pkt_written_span;

  // When calm is set, neither side inserts random idle gaps.
  bit               calm;
  // The stimulus asks for a long result stall by bumping stall_requests; the
  // result sink answers each request once and counts it in stall_served.
  int unsigned      stall_requests;
  int unsigned      stall_served;
  func_t            prev_func;
  int unsigned      cycle_count = 0;

  byte_ring_fifo_with_peek_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  brf_ring_check ring_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .results_pending  (results_pending),
    .pkt_written_span (pkt_written_span)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The run is ended here if it hangs, for instance when an expected result
  // never shows up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Idle gap length in cycles: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned pick;
    if (calm) return 0;
    pick = $urandom_range(99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Result sink. Each pass through the loop ends with out_ready high, so a stall
  // of any length can land on any beat of a read run.
  initial begin : result_sink
    int unsigned gap;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_requests != stall_served) begin
        // Long hold-off: the block fills up and must stall its input side.
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_served++;
        out_ready <= 1'b1;
      end else begin
        gap = idle_len();
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one input item and returns at the edge where it is transferred.
  // With no gap, in_valid simply stays high from the previous transfer.
  task automatic send_item(input func_t f, input logic [7:0] d, input logic fst,
                           input logic [RUN_W-1:0] n);
    int unsigned gap;
    in_item_t    it;
    gap           = idle_len();
    it.func       = f;
    it.data_in    = d;
    it.first      = fst;
    it.run_length = n;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    prev_func = f;
  endtask

  // Sends an enqueue run of the given number of bytes. The declared length
  // travels on every byte, though only the byte marked first is checked.
  task automatic enqueue_run(input int unsigned bytes, input logic [RUN_W-1:0] declared);
    int unsigned k;
    for (k = 0; k < bytes; k++) send_item(FN_ENQ, 8'($urandom), k == 0, declared);
  endtask

  // One random read. A packet read is kept within slots that were written at
  // some point, since the packet pointer may run past the write pointer. The
  // written span is a registered monitor output and lags; that is only unsafe
  // right after another packet read, so in_valid is dropped until the next edge.
  task automatic read_item(input int unsigned n);
    func_t       f;
    int unsigned span;
    case ($urandom_range(3))
      0, 1:    f = FN_DEQ;
      2:       f = FN_PEEK;
      default: f = FN_PKT;
    endcase
    if (f == FN_PKT) begin
      if (prev_func == FN_PKT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      span = pkt_written_span;
      if (span == 0) f = FN_PEEK;
      else if (n > span) n = $urandom_range(1, span);
    end
    send_item(f, 8'($urandom), 1'($urandom), RUN_W'(n));
  endtask

  // Stops offering input and waits until every expected result has been
  // transferred, then lets the block settle for QUIET_CYCLES.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic set_ring_length(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  // Hand-built walk through a ring of eight slots, which holds seven bytes.
  // Every packet read here stays on slots written earlier in the walk.
  task automatic directed_walk();
    set_ring_length(13'd8);
    send_item(FN_DEQ, 8'h00, 1'b0, 7'd1);      // empty ring: too few bytes
    send_item(FN_ENQ, 8'h00, 1'b1, 7'd4);      // four bytes, extreme values
    send_item(FN_ENQ, 8'hFF, 1'b0, 7'd4);
    send_item(FN_ENQ, 8'h5A, 1'b0, 7'd4);
    send_item(FN_ENQ, 8'hA5, 1'b0, 7'd4);
    send_item(FN_ENQ, 8'h11, 1'b1, 7'd0);      // zero run length
    send_item(FN_ENQ, 8'h22, 1'b0, 7'd0);      // stray byte with no open run
    send_item(FN_ENQ, 8'h33, 1'b1, 7'd64);     // longest run, far too little room
    send_item(FN_ENQ, 8'h44, 1'b1, 7'd4);      // needs four, three free: whole
    send_item(FN_ENQ, 8'h55, 1'b0, 7'd4);      //   run is dropped
    send_item(FN_ENQ, 8'h66, 1'b1, 7'd3);      // fills the ring exactly
    send_item(FN_ENQ, 8'h77, 1'b0, 7'd3);
    send_item(FN_ENQ, 8'h88, 1'b0, 7'd3);
    send_item(FN_ENQ, 8'h99, 1'b0, 7'd3);      // one byte beyond the run
    send_item(FN_PEEK, 8'h00, 1'b0, 7'd7);     // full ring, nothing moves
    send_item(FN_PKT, 8'h00, 1'b0, 7'd2);      // packet pointer to slot 2
    send_item(FN_DEQ, 8'h00, 1'b0, 7'd3);      // read pointer to slot 3
    send_item(FN_PKT, 8'h00, 1'b0, 7'd4);      // room judged from read pointer
    send_item(FN_ENQ, 8'hC3, 1'b1, 7'd2);      // wraps through the last slot
    send_item(FN_ENQ, 8'h3C, 1'b0, 7'd2);
    send_item(FN_PKT, 8'h00, 1'b0, 7'd4);      // packet read across the wrap
    send_item(FN_DEQ, 8'h00, 1'b0, 7'd64);     // longest read, too few bytes
    send_item(FN_PEEK, 8'h00, 1'b0, 7'd0);     // zero read length
    send_item(FN_PKT, 8'h00, 1'b0, 7'd127);    // read length beyond the limit
    send_item(FN_DEQ, 8'h00, 1'b0, 7'd6);      // empties the ring across the wrap
  endtask

  // One random phase at a given ring length. Most of it is well-formed runs
  // and reads of random size; the rest is broken runs, bad lengths and stray
  // bytes. Optionally the result sink is held off for a long stretch while
  // input keeps coming, or the sender pauses midway until all results are in.
  task automatic random_phase(input logic [CFG_W-1:0] ring_cfg, input int unsigned items,
                              input int unsigned max_n, input bit quiet_sides,
                              input bit hold_sink, input bit pause_midway);
    int unsigned sent;
    int unsigned n;
    int unsigned bytes;
    int unsigned bad;
    int unsigned pick;
    bit          paused;
    set_ring_length(ring_cfg);
    calm   = quiet_sides;
    paused = 1'b0;
    sent   = 0;
    if (hold_sink) stall_requests++;
    while (sent < items) begin
      pick = $urandom_range(99);
      n    = $urandom_range(1, max_n);
      if (pick < 45) begin
        // Runs are kept within what is left of the phase's item budget.
        if (n > items - sent) n = items - sent;
        enqueue_run(n, RUN_W'(n));
        sent += n;
      end else if (pick < 75) begin
        read_item(n);
        sent++;
      end else if (pick < 83) begin
        // A run that is cut short or overruns its declared length.
        if (n > items - sent) n = items - sent;
        bytes = $urandom_range(1) ? $urandom_range(1, n) : n + $urandom_range(1, 3);
        enqueue_run(bytes, RUN_W'(n));
        sent += bytes;
      end else if (pick < 90) begin
        bad = $urandom_range(1) ? 0 : $urandom_range(MAX_RUN + 1, 127);
        if ($urandom_range(1)) begin
          enqueue_run(2, RUN_W'(bad));
          sent += 2;
        end else begin
          send_item(func_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom),
                    RUN_W'(bad));
          sent++;
        end
      end else begin
        send_item(FN_ENQ, 8'($urandom), 1'b0, RUN_W'($urandom));
        sent++;
      end
      if (pause_midway && !paused && sent >= items / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    in_valid       = 1'b0;
    in_item        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    calm           = 1'b0;
    stall_requests = 0;
    stall_served   = 0;
    prev_func      = FN_ENQ;
    rst_n          = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_walk();

    // Register values run from all zeros to all ones; both ends clamp.
    random_phase(13'd0,    20, 3,  1'b0, 1'b0, 1'b0);
    random_phase(13'd2,    20, 3,  1'b0, 1'b0, 1'b0);
    random_phase(13'h1FFF, 40, 64, 1'b0, 1'b0, 1'b0);
    random_phase(13'd37,   50, 40, 1'b1, 1'b1, 1'b0);
    random_phase(13'd3,    20, 4,  1'b1, 1'b0, 1'b0);
    random_phase(13'd130,  50, 64, 1'b0, 1'b0, 1'b1);
    random_phase(13'd4096, 40, 64, 1'b0, 1'b0, 1'b0);
    random_phase(13'($urandom_range(4, 400)), 40, 24, 1'b0, 1'b0, 1'b0);

    drain_results();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== byte_ring_fifo_with_peek_core.f =====
rtl/brf_pkg.sv
rtl/brf_ram.sv
rtl/byte_ring_fifo_with_peek_core.sv
bench/brf_ring_check.sv
bench/testbench.sv
